// ===== hw/rtl/pidsl_pkg.sv =====
// Shared types and constants for the incremental PID speed loop.
// Used by the register block, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package pidsl_pkg;

	localparam int SETPOINT_W = 16;
	localparam int GAIN_W     = 32;
	localparam int ERRSUM_W   = 32;
	localparam int DRIVE_W    = 16;
	localparam int MV_W       = 64;

	// APB map: one 32-bit register every four bytes
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam int APB_ADDR_W = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SETPOINT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KP        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KI_DT     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KD_DIV_DT = 3'd4;

	localparam logic signed [ERRSUM_W-1:0] ERRSUM_MAX = {1'b0, {(ERRSUM_W-1){1'b1}}};
	localparam logic signed [ERRSUM_W-1:0] ERRSUM_MIN = {1'b1, {(ERRSUM_W-1){1'b0}}};
	localparam logic signed [DRIVE_W-1:0]  DRIVE_MAX  = {1'b0, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [DRIVE_W-1:0]  DRIVE_MIN  = {1'b1, {(DRIVE_W-1){1'b0}}};

	// Programmed loop settings, register block to datapath
	typedef struct packed {
		logic                         enable;
		logic signed [SETPOINT_W-1:0] setpoint;
		logic signed [GAIN_W-1:0]     kp;
		logic signed [GAIN_W-1:0]     ki_dt;
		logic signed [GAIN_W-1:0]     kd_div_dt;
	} cfg_t;

endpackage

// ===== hw/rtl/pidsl_regs.sv =====
// APB register block for the PID speed loop: enable, setpoint and three gains.
// Depends on pidsl_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module pidsl_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pidsl_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [pidsl_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pidsl_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	output pidsl_pkg::cfg_t                  cfg
);

	pidsl_pkg::cfg_t                      cfg_q;
	logic                                 wr_en;
	logic [pidsl_pkg::REG_IDX_W-1:0]      idx;

	assign pready = 1'b1;
	assign idx    = paddr[pidsl_pkg::APB_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				pidsl_pkg::REG_ENABLE:    cfg_q.enable    <= pwdata[0];
				pidsl_pkg::REG_SETPOINT:  cfg_q.setpoint  <= pwdata[pidsl_pkg::SETPOINT_W-1:0];
				pidsl_pkg::REG_KP:        cfg_q.kp        <= pwdata[pidsl_pkg::GAIN_W-1:0];
				pidsl_pkg::REG_KI_DT:     cfg_q.ki_dt     <= pwdata[pidsl_pkg::GAIN_W-1:0];
				pidsl_pkg::REG_KD_DIV_DT: cfg_q.kd_div_dt <= pwdata[pidsl_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pidsl_pkg::REG_ENABLE:    prdata = {{(pidsl_pkg::APB_DATA_W-1){1'b0}}, cfg_q.enable};
			pidsl_pkg::REG_SETPOINT:  prdata = {{(pidsl_pkg::APB_DATA_W-pidsl_pkg::SETPOINT_W){1'b0}},
							cfg_q.setpoint};
			pidsl_pkg::REG_KP:        prdata = cfg_q.kp;
			pidsl_pkg::REG_KI_DT:     prdata = cfg_q.ki_dt;
			pidsl_pkg::REG_KD_DIV_DT: prdata = cfg_q.kd_div_dt;
			default:                  prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/pidsl_datapath.sv =====
// Four-stage PID datapath with loop state and output register.
// Depends on pidsl_pkg for widths, saturation limits and cfg_t.
`timescale 1ns / 1ps

module pidsl_datapath #(
	parameter int MEAS_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pidsl_pkg::cfg_t                     cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [MEAS_WIDTH-1:0]               meas,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pidsl_pkg::DRIVE_W-1:0]       drive,
	output logic                                saturated
);

	localparam int EW    = ((MEAS_WIDTH > pidsl_pkg::SETPOINT_W) ?
				MEAS_WIDTH : pidsl_pkg::SETPOINT_W) + 1;
	localparam int DW    = EW + 1;
	localparam int SW    = pidsl_pkg::ERRSUM_W + 1;
	localparam int PKP_W = pidsl_pkg::GAIN_W + EW;
	localparam int PKI_W = pidsl_pkg::GAIN_W + pidsl_pkg::ERRSUM_W;
	localparam int PKD_W = pidsl_pkg::GAIN_W + DW;
	localparam int MV_W  = pidsl_pkg::MV_W;
	localparam int DRV_W = pidsl_pkg::DRIVE_W;

	// stage valids and load strobes
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic ld2, ld3, ld4, ld_out;

	// loop state
	logic signed [pidsl_pkg::ERRSUM_W-1:0] error_sum_q;
	logic signed [EW-1:0]                  prev_err_q;
	logic signed [DRV_W-1:0]               acc_q;

	// pipeline payload
	logic signed [MEAS_WIDTH-1:0]          meas_s1;
	logic signed [EW-1:0]                  err_s2;
	logic signed [pidsl_pkg::ERRSUM_W-1:0] sum_s2;
	logic signed [DW-1:0]                  delta_s2;
	logic                                  sat_s2;
	logic signed [PKP_W-1:0]               p_kp_s3;
	logic signed [PKI_W-1:0]               p_ki_s3;
	logic signed [PKD_W-1:0]               p_kd_s3;
	logic                                  sat_s3;
	logic signed [MV_W-1:0]                mv_s4;
	logic                                  sat_s4;
	logic [DRV_W-1:0]                      drive_q;
	logic                                  sat_q;

	// combinational
	logic signed [EW-1:0]                  err_c;
	logic signed [SW-1:0]                  sum_wide_c;
	logic                                  sum_ovf_c;
	logic signed [pidsl_pkg::ERRSUM_W-1:0] sum_c;
	logic signed [DW-1:0]                  delta_c;
	logic signed [PKP_W-1:0]               p_kp_c;
	logic signed [PKI_W-1:0]               p_ki_c;
	logic signed [PKD_W-1:0]               p_kd_c;
	logic signed [MV_W-1:0]                mv_c;
	logic signed [MV_W-1:0]                half_c;
	logic signed [MV_W-1:0]                acc_wide_c;
	logic [MV_W-DRV_W:0]                   acc_hi_c;
	logic                                  acc_pos_ovf_c, acc_neg_ovf_c;
	logic signed [DRV_W-1:0]               acc_c;

	// a stage loads when it holds an item and the next slot is free or emptying
	assign ld_out   = v_s4 & (~out_valid_q | out_ready);
	assign ld4      = v_s3 & (~v_s4 | ld_out);
	assign ld3      = v_s2 & (~v_s3 | ld4);
	assign ld2      = v_s1 & (~v_s2 | ld3);
	assign in_ready = ~v_s1 | ld2;

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

	// stage 1 -> 2: error, saturating sum, difference
	assign err_c      = EW'(cfg.setpoint) - EW'(meas_s1);
	assign sum_wide_c = SW'(error_sum_q) + SW'(err_c);
	assign sum_ovf_c  = sum_wide_c[SW-1] ^ sum_wide_c[SW-2];
	assign sum_c      = !sum_ovf_c ? sum_wide_c[SW-2:0] :
			    (sum_wide_c[SW-1] ? pidsl_pkg::ERRSUM_MIN : pidsl_pkg::ERRSUM_MAX);
	assign delta_c    = DW'(err_c) - DW'(prev_err_q);

	// stage 2 -> 3: three independent products
	assign p_kp_c = PKP_W'(cfg.kp) * PKP_W'(err_s2);
	assign p_ki_c = PKI_W'(cfg.ki_dt) * PKI_W'(sum_s2);
	assign p_kd_c = PKD_W'(cfg.kd_div_dt) * PKD_W'(delta_s2);

	// stage 3 -> 4: sum of terms in Q16.16
	assign mv_c = MV_W'(p_kp_s3) + MV_W'(p_ki_s3) + MV_W'(p_kd_s3);

	// stage 4 -> out: Q1.15 by floor halving, accumulate and clip
	assign half_c        = mv_s4 >>> 1;
	assign acc_wide_c    = MV_W'(acc_q) + half_c;
	assign acc_hi_c      = acc_wide_c[MV_W-1:DRV_W-1];
	assign acc_pos_ovf_c = ~acc_wide_c[MV_W-1] & (|acc_hi_c);
	assign acc_neg_ovf_c = acc_wide_c[MV_W-1] & ~(&acc_hi_c);
	assign acc_c         = acc_pos_ovf_c ? pidsl_pkg::DRIVE_MAX :
			       acc_neg_ovf_c ? pidsl_pkg::DRIVE_MIN : acc_wide_c[DRV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			error_sum_q <= '0;
			prev_err_q  <= '0;
			acc_q       <= '0;
		end else begin
			v_s1        <= (in_valid & in_ready) | (v_s1 & ~ld2);
			v_s2        <= ld2 | (v_s2 & ~ld3);
			v_s3        <= ld3 | (v_s3 & ~ld4);
			v_s4        <= ld4 | (v_s4 & ~ld_out);
			out_valid_q <= ld_out | (out_valid_q & ~out_ready);
			if (ld2 && cfg.enable) begin
				error_sum_q <= sum_c;
				prev_err_q  <= err_c;
			end
			if (ld_out && cfg.enable) begin
				acc_q <= acc_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_s1 <= meas;
		end
		if (ld2) begin
			err_s2   <= err_c;
			sum_s2   <= sum_c;
			delta_s2 <= delta_c;
			sat_s2   <= sum_ovf_c;
		end
		if (ld3) begin
			p_kp_s3 <= p_kp_c;
			p_ki_s3 <= p_ki_c;
			p_kd_s3 <= p_kd_c;
			sat_s3  <= sat_s2;
		end
		if (ld4) begin
			mv_s4  <= mv_c;
			sat_s4 <= sat_s3;
		end
		if (ld_out) begin
			// disabled ticks drive zero and flag nothing
			drive_q <= cfg.enable ? acc_c : '0;
			sat_q   <= cfg.enable & (sat_s4 | acc_pos_ovf_c | acc_neg_ovf_c);
		end
	end

endmodule

// ===== hw/rtl/incremental_pid_speed_loop.sv =====
// Top level of the incremental PID speed loop: APB registers and datapath.
// Depends on pidsl_pkg, pidsl_regs and pidsl_datapath.
`timescale 1ns / 1ps

// Usage
// - s_* stream: one request per control tick carrying the measured speed
//   (signed, MEAS_WIDTH bits, low end of s_tdata).
// - m_* stream: one result per request; m_tdata is the Q1.15 drive after the
//   tick, m_tuser flags that the error sum or the drive was clipped.
// - APB port: enable, setpoint, kp, ki_dt, kd_div_dt at byte addresses
//   0x00..0x10. Write only while no request is in flight.
// A request accepted on s_* passes the input register, the error/sum stage,
// the product stage, the term-sum stage and the output register before its
// result shows on m_*. Throughput: one request per cycle while m_* is not
// stalled; the error sum and drive accumulator are each updated by a
// combinational add-and-clip loop around its own register, which sets the rate.
// Stalls: while m_tready is low the result holds; the four stages ahead of it
// keep filling, so up to five requests can be held before s_tready drops.
// Reset (arst_n low): configuration and loop state zero, loop disabled, pipeline
// empty; data registers are not reset. Disabled ticks still return one result,
// with drive zero and no flag, and leave the loop state as it was.

module incremental_pid_speed_loop #(
	parameter int MEAS_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pidsl_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [pidsl_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pidsl_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	// measurement stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((MEAS_WIDTH+7)/8)*8-1:0]     s_tdata,   // measured_speed, zero padded
	// drive stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pidsl_pkg::DRIVE_W-1:0]       m_tdata,   // drive
	output logic                                m_tuser    // saturated
);

	pidsl_pkg::cfg_t cfg;

	pidsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// padding bits above the measurement are ignored
	pidsl_datapath #(
		.MEAS_WIDTH (MEAS_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.meas      (s_tdata[MEAS_WIDTH-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.drive     (m_tdata),
		.saturated (m_tuser)
	);

endmodule

// ===== hw/rtl/pidsl_chk.sv =====
// Port-level checker for the PID speed loop, bound to the top level.
// Depends on pidsl_pkg for the drive width.
`timescale 1ns / 1ps

module pidsl_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pidsl_pkg::DRIVE_W-1:0] m_tdata,
	input logic                          m_tuser
);

	// requests accepted but not yet delivered; the block holds at most five
	logic [2:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_no_result_without_request: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 3'd0)
		else $error("result shown with no request outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd5)
		else $error("more requests in flight than pipeline slots");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> s_tready)
		else $error("input stalled while pipeline empty");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind incremental_pid_speed_loop pidsl_chk u_pidsl_chk (.*);
